[rtl/goe_pkg.sv]
// Shared constants, types and register codes of the obstacle border erode block.
package goe_pkg;

  localparam int MAX_COLS  = 1024;
  localparam int CELL_BITS = 8;
  localparam int ADDR_W    = $clog2(MAX_COLS);
  localparam int CODE_W    = 8;
  localparam int ROWS_W    = 16;
  localparam int COLS_W    = 11;
  localparam int ROW_W     = 17;
  localparam int EMIT_W    = 26;
  localparam int TOTAL_W   = ROWS_W + COLS_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int LINE_W    = 2 * CELL_BITS;

  typedef logic [CELL_BITS-1:0] cell_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREE    = 2'd0,
    REG_BLOCKED = 2'd1,
    REG_ROWS    = 2'd2,
    REG_COLS    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    cell_t top;
    cell_t mid;
    cell_t bot;
  } win_col_t;

  typedef struct packed {
    logic has_result;
    logic last;
    logic up;
    logic down;
    logic left;
    logic right;
  } pos_tag_t;

endpackage

[rtl/grid_obstacle_border_erode_unit.sv]
// Top level of the 3x3 obstacle border erode block on a raster occupancy grid.
// Throughput is one item per cycle while in_ready is high; the line buffer RAM is read and
// written once per item. A result passes the s1, s2 and output registers after the item
// that causes it is accepted, and a cell's result is caused by the item grid_cols+1
// positions after it. After reset the line buffer is cleared with in_ready low,
// and in_ready also drops for one cycle after each configuration write.
module grid_obstacle_border_erode_unit
  import goe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CELL_BITS-1:0] cell_code,
  input  logic                 is_pad,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CELL_BITS-1:0] out_code,
  output logic                 was_border,
  output logic                 last_cell
);

  logic [CODE_W-1:0]  free_code;
  logic [CODE_W-1:0]  blocked_code;
  logic [ROWS_W-1:0]  grid_rows;
  logic [COLS_W-1:0]  grid_cols;
  logic [ROWS_W-1:0]  eff_rows;
  logic [COLS_W-1:0]  eff_cols;
  logic [TOTAL_W-1:0] total;
  logic               cfg_settle;

  logic               clearing;
  logic [ADDR_W-1:0]  clr_addr;

  logic               accept;
  logic               out_free;
  logic               s2_adv;
  logic               s1_adv;
  logic               s1_leave;
  logic [ADDR_W-1:0]  slot;
  pos_tag_t           in_tag;

  logic               s1_valid;
  cell_t              s1_cell;
  logic [ADDR_W-1:0]  s1_slot;
  pos_tag_t           s1_tag;
  logic               s1_byp;
  logic [LINE_W-1:0]  s1_byp_data;
  logic [LINE_W-1:0]  ram_rdata;
  logic [LINE_W-1:0]  line_rd;
  logic [LINE_W-1:0]  line_wr;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [LINE_W-1:0]  ram_wdata;

  logic               s2_valid;
  pos_tag_t           s2_tag;
  win_col_t           new_col;
  win_col_t           col0;
  win_col_t           col1;
  win_col_t           col2;

  cell_t              fc;
  cell_t              bc;
  logic               border;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_code    <= CODE_W'(0);
      blocked_code <= CODE_W'(1);
      grid_rows    <= ROWS_W'(1);
      grid_cols    <= COLS_W'(1);
      cfg_settle   <= 1'b0;
      total        <= TOTAL_W'(1);
    end else begin
      cfg_settle <= cfg_we;
      total      <= TOTAL_W'(eff_rows) * TOTAL_W'(eff_cols);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_FREE:    free_code    <= cfg_data[CODE_W-1:0];
          REG_BLOCKED: blocked_code <= cfg_data[CODE_W-1:0];
          REG_ROWS:    grid_rows    <= cfg_data[ROWS_W-1:0];
          REG_COLS:    grid_cols    <= cfg_data[COLS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    eff_rows = (grid_rows == '0) ? ROWS_W'(1) : grid_rows;
    if (grid_cols == '0) begin
      eff_cols = COLS_W'(1);
    end else if (grid_cols > COLS_W'(MAX_COLS)) begin
      eff_cols = COLS_W'(MAX_COLS);
    end else begin
      eff_cols = grid_cols;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(MAX_COLS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign out_free = !out_valid || out_ready;
  assign s2_adv   = !s2_valid || out_free;
  assign s1_adv   = !s1_valid || s2_adv;
  assign s1_leave = s1_valid && s2_adv;
  assign in_ready = s1_adv && !clearing && !cfg_settle;
  assign accept   = in_valid && in_ready;

  goe_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .rows   (eff_rows),
    .cols   (eff_cols),
    .total  (total),
    .slot   (slot),
    .tag    (in_tag)
  );

  assign line_rd   = s1_byp ? s1_byp_data : ram_rdata;
  assign line_wr   = {line_rd[CELL_BITS-1:0], s1_cell};
  assign ram_we    = clearing || s1_leave;
  assign ram_waddr = clearing ? clr_addr : s1_slot;
  assign ram_wdata = clearing ? '0 : line_wr;

  goe_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s1_adv),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_cell     <= is_pad ? '0 : cell_code;
      s1_slot     <= slot;
      s1_tag      <= in_tag;
      s1_byp      <= s1_leave && (s1_slot == slot);
      s1_byp_data <= line_wr;
    end
  end

  assign new_col.top = line_rd[LINE_W-1:CELL_BITS];
  assign new_col.mid = line_rd[CELL_BITS-1:0];
  assign new_col.bot = s1_cell;

  goe_win_col u_col2 (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_leave),
    .col_in  (new_col),
    .col_out (col2)
  );

  goe_win_col u_col1 (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_leave),
    .col_in  (col2),
    .col_out (col1)
  );

  goe_win_col u_col0 (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_leave),
    .col_in  (col1),
    .col_out (col0)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_tag <= s1_tag;
    end
  end

  always_comb begin
    fc = free_code[CELL_BITS-1:0];
    bc = blocked_code[CELL_BITS-1:0];
    border = (col1.mid == bc) && (
      (s2_tag.up && col1.top == fc) ||
      (s2_tag.down && col1.bot == fc) ||
      (s2_tag.left && col0.mid == fc) ||
      (s2_tag.right && col2.mid == fc) ||
      (s2_tag.up && s2_tag.left && col0.top == fc) ||
      (s2_tag.up && s2_tag.right && col2.top == fc) ||
      (s2_tag.down && s2_tag.left && col0.bot == fc) ||
      (s2_tag.down && s2_tag.right && col2.bot == fc));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid && s2_tag.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_code   <= border ? fc : col1.mid;
      was_border <= border;
      last_cell  <= s2_tag.last;
    end
  end

endmodule

[rtl/goe_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module goe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

[rtl/goe_win_col.sv]
// One column cell of the 3x3 window, loaded from its right-hand neighbor.
module goe_win_col
  import goe_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     shift,
  input  win_col_t col_in,
  output win_col_t col_out
);

  win_col_t col;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

  assign col_out = col;

endmodule

[rtl/goe_ctrl.sv]
// Raster position tracking: input row and column, emitted count and window bounds.
module goe_ctrl
  import goe_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [ROWS_W-1:0]   rows,
  input  logic [COLS_W-1:0]   cols,
  input  logic [TOTAL_W-1:0]  total,
  output logic [ADDR_W-1:0]   slot,
  output pos_tag_t            tag
);

  logic [ROW_W-1:0]  in_row;
  logic [ROW_W-1:0]  in_row_next;
  logic [ADDR_W-1:0] in_col;
  logic [ADDR_W-1:0] in_col_next;
  logic [EMIT_W-1:0] cells_emitted;
  logic [EMIT_W-1:0] cells_emitted_next;
  logic              col_zero;
  logic              crow_neg;
  logic              col_wrap;
  logic [ROW_W-1:0]  crow;
  logic [ADDR_W-1:0] ccol;

  always_comb begin
    col_zero = (in_col == '0);
    crow_neg = col_zero ? (in_row < ROW_W'(2)) : (in_row == '0);
    crow     = in_row - (col_zero ? ROW_W'(2) : ROW_W'(1));
    ccol     = col_zero ? ADDR_W'(cols - COLS_W'(1)) : in_col - ADDR_W'(1);
    col_wrap = (COLS_W'(in_col) + COLS_W'(1)) >= cols;

    tag.has_result = !crow_neg;
    tag.up         = (crow != '0);
    tag.down       = ({1'b0, crow} + (ROW_W + 1)'(1)) < (ROW_W + 1)'(rows);
    tag.left       = (ccol != '0);
    tag.right      = (COLS_W'(ccol) + COLS_W'(1)) < cols;
    tag.last       = !crow_neg &&
                     ((TOTAL_W'(cells_emitted) + TOTAL_W'(1)) >= total);

    in_row_next        = in_row;
    in_col_next        = in_col;
    cells_emitted_next = cells_emitted;
    if (accept) begin
      if (tag.last) begin
        in_row_next        = '0;
        in_col_next        = '0;
        cells_emitted_next = '0;
      end else begin
        if (col_wrap) begin
          in_col_next = '0;
          in_row_next = in_row + ROW_W'(1);
        end else begin
          in_col_next = in_col + ADDR_W'(1);
        end
        if (tag.has_result) begin
          cells_emitted_next = cells_emitted + EMIT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row        <= '0;
      in_col        <= '0;
      cells_emitted <= '0;
    end else begin
      in_row        <= in_row_next;
      in_col        <= in_col_next;
      cells_emitted <= cells_emitted_next;
    end
  end

  assign slot = in_col;

endmodule

[bench/border_erode_checker.sv]
// Checker that predicts the eroded grid cells and compares them with the block's results.
`timescale 1ns / 1ps

module border_erode_checker
  import goe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CELL_BITS-1:0] cell_code,
  input  logic                 is_pad,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [CELL_BITS-1:0] out_code,
  input  logic                 was_border,
  input  logic                 last_cell,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    cell_t code;
    logic  border;
    logic  last;
  } eroded_cell_t;

  cell_t             free_reg;
  cell_t             blocked_reg;
  logic [ROWS_W-1:0] rows_reg;
  logic [COLS_W-1:0] cols_reg;

  cell_t             line_above [MAX_COLS];
  cell_t             line_cur [MAX_COLS];
  cell_t             win [9];
  logic [ROW_W-1:0]  row_pos;
  logic [COLS_W-1:0] col_pos;
  logic [EMIT_W-1:0] cells_out;

  eroded_cell_t      expected_cells [$];
  eroded_cell_t      got;
  eroded_cell_t      want;
  eroded_cell_t      next_cell;
  logic              emits;
  int                idx;

  initial mismatches = 0;
  initial outstanding = 0;

  task automatic erode_predict(input cell_t code, input logic pad,
                               output logic emit, output eroded_cell_t res);
    int unsigned     rows;
    int unsigned     cols;
    int unsigned     slot;
    int unsigned     ccol;
    int              crow;
    longint unsigned area;
    cell_t           cur_cell;
    cell_t           center;
    logic            up;
    logic            down;
    logic            left;
    logic            right;
    logic            border;
    rows = (rows_reg == 0) ? 1 : rows_reg;
    cols = (cols_reg == 0) ? 1 : cols_reg;
    if (cols > MAX_COLS) cols = MAX_COLS;
    cur_cell = pad ? '0 : code;
    slot = col_pos % MAX_COLS;

    win[0] = win[1]; win[1] = win[2];
    win[3] = win[4]; win[4] = win[5];
    win[6] = win[7]; win[7] = win[8];
    win[2] = line_above[slot];
    win[5] = line_cur[slot];
    win[8] = cur_cell;
    line_above[slot] = line_cur[slot];
    line_cur[slot] = cur_cell;

    if (col_pos == 0) begin
      crow = int'(row_pos) - 2;
      ccol = cols - 1;
    end else begin
      crow = int'(row_pos) - 1;
      ccol = col_pos - 1;
    end

    if (col_pos + 1 >= cols) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end

    emit = (crow >= 0);
    res = '0;
    if (emit) begin
      up = (crow > 0);
      down = (crow + 1 < rows);
      left = (ccol > 0);
      right = (ccol + 1 < cols);
      center = win[4];
      border = 1'b0;
      if (center == blocked_reg) begin
        border = (up && win[1] == free_reg) || (down && win[7] == free_reg) ||
                 (left && win[3] == free_reg) || (right && win[5] == free_reg) ||
                 (up && left && win[0] == free_reg) ||
                 (up && right && win[2] == free_reg) ||
                 (down && left && win[6] == free_reg) ||
                 (down && right && win[8] == free_reg);
      end
      area = longint'(rows) * longint'(cols);
      res.code = border ? free_reg : center;
      res.border = border;
      res.last = (longint'(cells_out) + 1 >= area);
      if (res.last) begin
        row_pos = '0;
        col_pos = '0;
        cells_out = '0;
      end else begin
        cells_out = cells_out + 1'b1;
      end
    end
  endtask

  task automatic log_mismatch(input logic waiting, input eroded_cell_t exp_c,
                              input eroded_cell_t act);
    mismatches++;
    if (mismatches <= 10) begin
      if (!waiting)
        $display("unexpected result: code %0d border %0b last %0b",
                 act.code, act.border, act.last);
      else
        $display({"cell mismatch: expected code %0d border %0b last %0b, ",
                  "got code %0d border %0b last %0b"},
                 exp_c.code, exp_c.border, exp_c.last, act.code, act.border, act.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      free_reg = 8'd0;
      blocked_reg = 8'd1;
      rows_reg = 16'd1;
      cols_reg = 11'd1;
      for (idx = 0; idx < MAX_COLS; idx++) begin
        line_above[idx] = '0;
        line_cur[idx] = '0;
      end
      for (idx = 0; idx < 9; idx++) win[idx] = '0;
      row_pos = '0;
      col_pos = '0;
      cells_out = '0;
      expected_cells.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FREE:    free_reg = cfg_data[CODE_W-1:0];
          REG_BLOCKED: blocked_reg = cfg_data[CODE_W-1:0];
          REG_ROWS:    rows_reg = cfg_data[ROWS_W-1:0];
          REG_COLS:    cols_reg = cfg_data[COLS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        erode_predict(cell_code, is_pad, emits, next_cell);
        if (emits) expected_cells.push_back(next_cell);
      end
      if (out_valid && out_ready) begin
        got.code = out_code;
        got.border = was_border;
        got.last = last_cell;
        if (expected_cells.size() == 0) begin
          log_mismatch(1'b0, got, got);
        end else begin
          want = expected_cells.pop_front();
          if (got.code != want.code || got.border != want.border || got.last != want.last)
            log_mismatch(1'b1, want, got);
        end
      end
    end
    outstanding <= expected_cells.size();
  end

endmodule

[bench/grid_obstacle_border_erode_unit_tb.sv]
// Top of the obstacle border erode testbench: stimulus, reset, watchdog and verdict.
`timescale 1ns / 1ps

module grid_obstacle_border_erode_unit_tb;
  import goe_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int HOLD_AT        = 150;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 460;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CELL_BITS-1:0] cell_code = '0;
  logic                 is_pad = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CELL_BITS-1:0] out_code;
  logic                 was_border;
  logic                 last_cell;

  int                   mismatches;
  int                   outstanding;
  int                   items_sent = 0;
  int                   quiet_cycles = 0;
  bit                   tx_quiet = 1'b0;
  cell_t                free_now = 8'd0;
  cell_t                blocked_now = 8'd1;

  always #4 clk = ~clk;

  grid_obstacle_border_erode_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cell_code(cell_code), .is_pad(is_pad),
    .out_valid(out_valid), .out_ready(out_ready), .out_code(out_code),
    .was_border(was_border), .last_cell(last_cell)
  );

  border_erode_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cell_code(cell_code), .is_pad(is_pad),
    .out_valid(out_valid), .out_ready(out_ready), .out_code(out_code),
    .was_border(was_border), .last_cell(last_cell),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(input cell_t code, input logic pad);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cell_code <= code;
    is_pad <= pad;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_cell();
    int pick;
    pick = $urandom_range(0, 39);
    if (pick < 16) send_item(free_now, 1'b0);
    else if (pick < 32) send_item(blocked_now, 1'b0);
    else if (pick < 38) send_item(cell_t'($urandom()), 1'b0);
    else send_item(cell_t'($urandom()), 1'b1);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] fr, input logic [15:0] bl,
                           input logic [15:0] rows_w, input logic [15:0] cols_w);
    cfg_we <= 1'b1;
    cfg_index <= REG_FREE;
    cfg_data <= fr;
    @(posedge clk);
    cfg_index <= REG_BLOCKED;
    cfg_data <= bl;
    @(posedge clk);
    cfg_index <= REG_ROWS;
    cfg_data <= rows_w;
    @(posedge clk);
    cfg_index <= REG_COLS;
    cfg_data <= cols_w;
    @(posedge clk);
    cfg_we <= 1'b0;
    free_now = fr[7:0];
    blocked_now = bl[7:0];
  endtask

  // A truncated frame stops early; an overlong one starts the next frame early.
  task automatic run_frame(input int rows_n, input int cols_n, input int shape);
    int cells;
    int len;
    int k;
    cells = rows_n * cols_n;
    len = cells + cols_n + 1;
    if (shape == 1) len = $urandom_range(1, len - 1);
    for (k = 0; k < len; k++) begin
      if (k < cells) send_cell();
      else send_item(cell_t'($urandom()), 1'b1);
    end
    if (shape == 2) repeat ($urandom_range(1, 5)) send_cell();
  endtask

  initial begin : result_sink
    int gap;
    int taken;
    bit rx_quiet;
    taken = 0;
    rx_quiet = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      else if (rx_quiet) gap = 0;
      else gap = $urandom_range(0, 11);
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    cell_t       pattern [9];
    int          k;
    int          n;
    int          shape;
    int          rows_w;
    int          cols_w;
    int          random_start;
    cell_t       fr;
    cell_t       bl;
    logic [15:0] d_free;
    logic [15:0] d_blk;
    logic [15:0] d_cols;
    pattern = '{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hAA, 8'hFF, 8'hFF};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Single cell grid with the reset settings.
    send_item(8'd1, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b1);
    drain_block();

    // Three by three grid with the code extremes and a pad inside the frame.
    configure(16'h0000, 16'h00FF, 16'd3, 16'd3);
    for (k = 0; k < 9; k++) send_item(pattern[k], k == 6);
    repeat (4) send_item(cell_t'($urandom()), 1'b1);
    drain_block();

    // Free and blocked codes equal; upper data bits are ignored.
    configure(16'hAB07, 16'h5407, 16'd2, 16'd2);
    send_item(8'd7, 1'b0);
    send_item(8'd7, 1'b0);
    send_item(8'd7, 1'b0);
    send_item(8'd3, 1'b0);
    repeat (3) send_item(cell_t'($urandom()), 1'b1);
    drain_block();

    // Zero rows acts as one.
    configure(16'h0000, 16'h00FF, 16'd0, 16'd5);
    run_frame(1, 5, 0);
    drain_block();

    // Tallest grid left unfinished, then resized while partly streamed.
    configure(16'h0000, 16'h00FF, 16'hFFFF, 16'd1024);
    repeat (60) send_cell();
    drain_block();
    configure(16'h0055, 16'h00AA, 16'hFFFF, 16'd2);
    repeat (40) send_cell();
    drain_block();
    configure(16'h0055, 16'h00AA, 16'd3, 16'd2);
    repeat (8) send_cell();
    drain_block();

    random_start = items_sent;
    while (items_sent < random_start + RANDOM_ITEMS) begin
      rows_w = $urandom_range(0, 7);
      if ($urandom_range(0, 5) == 0) cols_w = $urandom_range(13, 40);
      else cols_w = $urandom_range(0, 12);
      fr = cell_t'($urandom());
      bl = ($urandom_range(0, 7) == 0) ? fr : cell_t'($urandom());
      d_free = 16'($urandom());
      d_blk = 16'($urandom());
      d_cols = 16'($urandom());
      d_free[7:0] = fr;
      d_blk[7:0] = bl;
      d_cols[10:0] = 11'(cols_w);
      configure(d_free, d_blk, 16'(rows_w), d_cols);
      tx_quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(0, 7);
      shape = (n == 0) ? 1 : ((n == 1) ? 2 : 0);
      run_frame((rows_w == 0) ? 1 : rows_w, (cols_w == 0) ? 1 : cols_w, shape);
      drain_block();
    end

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
